>>> rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, register indexes and request/response types of the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int WIDTH     = 64;
    localparam int BIT_CNT_W = $clog2(WIDTH);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(1);

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
    } mexp_mul_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WIDTH-1:0] product;
    } mexp_mul_rsp_t;

endpackage

>>> rtl/mexp_base_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_base_if
// Valid/ready channel carrying one base value per request.
// ----------------------------------------------------------------------------
interface mexp_base_if
    import mexp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink   (input valid, input base_value, output ready);
endinterface

>>> rtl/mexp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_result_if
// Valid/ready channel carrying one power result per request.
// ----------------------------------------------------------------------------
interface mexp_result_if
    import mexp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

>>> rtl/mexp_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: a * b mod m, multiplier bits MSB first,
// one double-and-reduce or add-and-reduce per cycle. m of zero wraps.
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mexp_mul_req_t    req,
    input  logic [WIDTH-1:0] modulus,
    output mexp_mul_rsp_t    rsp
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DBL  = 3'b010,
        PH_ADD  = 3'b100
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [WIDTH-1:0]     a_reg, a_next;
    logic [WIDTH-1:0]     b_reg, b_next;
    logic [WIDTH-1:0]     acc_reg, acc_next;

    logic [WIDTH-1:0]     addend;
    logic [WIDTH:0]       sum;
    logic [WIDTH:0]       diff;
    logic [WIDTH-1:0]     reduced;
    logic                 last_bit;

    // acc, addend < m, so one conditional subtract suffices
    always_comb
    begin
        addend = (phase_reg == PH_ADD) ? a_reg : acc_reg;
        sum    = {1'b0, acc_reg} + {1'b0, addend};
        diff   = sum - {1'b0, modulus};
        if (modulus == '0)
        begin
            reduced = sum[WIDTH-1:0];
        end
        else if (!diff[WIDTH])
        begin
            reduced = diff[WIDTH-1:0];
        end
        else
        begin
            reduced = sum[WIDTH-1:0];
        end
    end

    always_comb
    begin
        last_bit   = (cnt_reg == '0);
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.a;
                    b_next     = req.b;
                    acc_next   = '0;
                    cnt_next   = BIT_CNT_W'(WIDTH - 1);
                    phase_next = PH_DBL;
                end
            end
            PH_DBL:
            begin
                acc_next = reduced;
                if (b_reg[WIDTH-1])
                begin
                    phase_next = PH_ADD;
                end
                else if (last_bit)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    b_next   = b_reg << 1;
                end
            end
            PH_ADD:
            begin
                acc_next = reduced;
                if (last_bit)
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    b_next     = b_reg << 1;
                    phase_next = PH_DBL;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.busy    = (phase_reg != PH_IDLE);
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

>>> rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// base_value ^ exponent mod modulus, right-to-left square-and-multiply on
// one shared bit-serial modular multiplier.
//
//   channel   dir   handshake       payload
//   operand   in    valid/ready     base_value   [63:0]
//   result    out   valid/ready     power_result [63:0]
//   cfg       in    cfg_we          cfg_index, cfg_data [63:0]
//
// One modular multiply does a double step per multiplier bit and an add step
// per set bit. A request takes one base reduction, one squaring per exponent
// bit up to the top set bit (the last one skipped) and one multiply per set
// bit; a zero exponent skips the multiplier and gives 1.
// operand.ready is high only while idle; a finished result waits in the
// output register, the next request is taken meanwhile.
// Reset leaves modulus = 1, exponent = 1, no result pending.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH-1:0]     cfg_data,
    mexp_base_if.sink            operand,
    mexp_result_if.source        result
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_STEP   = 6'b000100,
        S_MUL_P  = 6'b001000,
        S_MUL_S  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] modulus_reg, modulus_next;
    logic [WIDTH-1:0] exponent_reg, exponent_next;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;
    logic [WIDTH-1:0] product_reg, product_next;
    logic [WIDTH-1:0] square_reg, square_next;
    logic [WIDTH-1:0] rem_exp_reg, rem_exp_next;

    mexp_mul_req_t    mul_req;
    mexp_mul_rsp_t    mul_rsp;
    logic             in_fire;

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .modulus (modulus_reg),
        .rsp     (mul_rsp)
    );

    assign operand.ready = (state_reg == S_IDLE);
    assign in_fire       = operand.valid && operand.ready;
    assign result.valid        = out_valid_reg;
    assign result.power_result = out_data_reg;

    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODULUS:  modulus_next  = cfg_data;
                CFG_EXPONENT: exponent_next = cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        product_next   = product_reg;
        square_next    = square_reg;
        rem_exp_next   = rem_exp_reg;
        mul_req.start  = 1'b0;
        mul_req.a      = square_reg;
        mul_req.b      = square_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (exponent_reg == '0)
                    begin
                        product_next = WIDTH'(1);
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        // base mod m as 1 * base mod m
                        mul_req.start = 1'b1;
                        mul_req.a     = WIDTH'(1);
                        mul_req.b     = operand.base_value;
                        product_next  = (modulus_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
                        rem_exp_next  = exponent_reg;
                        state_next    = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mul_rsp.done)
                begin
                    square_next = mul_rsp.product;
                    state_next  = S_STEP;
                end
            end
            S_STEP:
            begin
                if (rem_exp_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (rem_exp_reg[0])
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = product_reg;
                    state_next    = S_MUL_P;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_MUL_S;
                end
            end
            S_MUL_P:
            begin
                if (mul_rsp.done)
                begin
                    product_next = mul_rsp.product;
                    if (rem_exp_reg[WIDTH-1:1] == '0)
                    begin
                        rem_exp_next = '0;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        mul_req.start = 1'b1;
                        state_next    = S_MUL_S;
                    end
                end
            end
            S_MUL_S:
            begin
                if (mul_rsp.done)
                begin
                    square_next  = mul_rsp.product;
                    rem_exp_next = rem_exp_reg >> 1;
                    state_next   = S_STEP;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_data_next  = product_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= WIDTH'(1);
            exponent_reg  <= WIDTH'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        product_reg  <= product_next;
        square_reg   <= square_next;
        rem_exp_reg  <= rem_exp_next;
    end

    // multiplier is started only when free
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiply started while multiplier busy");

    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |->
            (state_reg == S_REDUCE || state_reg == S_MUL_P || state_reg == S_MUL_S))
        else $error("multiply completion outside a multiply state");

    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && exponent_reg == '0 |=> state_reg == S_FINISH && product_reg == WIDTH'(1))
        else $error("zero exponent did not short-cut to result");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !operand.ready)
        else $error("request taken while previous request in progress");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && modulus_reg > WIDTH'(1) |-> out_data_reg < modulus_reg)
        else $error("result not reduced below modulus");

endmodule
